[hw/rtl/hextb_pkg.sv]
// ---------------------------------------------------------------------------
// Hex text decoder package
// Shared types, codes and character classification for the hex text decoder.
// ---------------------------------------------------------------------------
package hextb_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] TERM_NONE = 3'd0;
   localparam logic [2:0] TERM_LF   = 3'd1;
   localparam logic [2:0] TERM_CR   = 3'd2;
   localparam logic [2:0] TERM_CRLF = 3'd3;
   localparam logic [2:0] TERM_NUL  = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_HEX = 2'd1;
   localparam logic [1:0] STATUS_ODD     = 2'd2;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STEP_DATA  = 2'd0;
   localparam logic [1:0] STEP_TERM1 = 2'd1;
   localparam logic [1:0] STEP_TERM2 = 2'd2;
   localparam logic [1:0] STEP_STAT  = 2'd3;

   localparam logic [15:0] CHAR_COMMA = 16'h002C;
   localparam logic [15:0] CHAR_COLON = 16'h003A;
   localparam logic [15:0] CHAR_DASH  = 16'h002D;
   localparam logic [15:0] CHAR_SEMI  = 16'h003B;
   localparam logic [15:0] CHAR_ZERO  = 16'h0030;
   localparam logic [15:0] CHAR_LOW_X = 16'h0078;
   localparam logic [15:0] CHAR_UP_X  = 16'h0058;

   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_NUL = 8'h00;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  byte_val;
      logic        is_end;
      logic [1:0]  status;
      logic [15:0] bad_char;
      logic [2:0]  term;
   } entry_type;

   function automatic logic is_white(input logic [15:0] c);
      return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
             c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
             c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
             c == 16'h3000;
   endfunction

   function automatic logic is_separator(input logic [15:0] c);
      return is_white(c) || c == CHAR_COMMA || c == CHAR_COLON || c == CHAR_DASH ||
             c == CHAR_SEMI;
   endfunction

   // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_value(input logic [15:0] c);
      logic [4:0] v;
      v = 5'd0;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         v = {1'b1, c[3:0]};
      end else if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066)) begin
         v = {1'b1, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

[hw/rtl/hextb_front.sv]
// ---------------------------------------------------------------------------
// Hex text decoder front end
// Classifies each character, merges nibbles and builds one queue entry per
// item that yields a byte or ends the message.
// ---------------------------------------------------------------------------
module hextb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_write_data,
   input  logic                 accept,
   input  logic [15:0]          char_code,
   input  logic                 has_char,
   input  logic                 end_of_text,
   output logic                 push,
   output hextb_pkg::entry_type entry
);
   import hextb_pkg::*;

   logic [2:0]  term_mode_ff;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic        nibble_held_ff, nibble_held_in;
   logic        zero_pending_ff, zero_pending_in;
   logic        error_seen_ff, error_seen_in;
   logic [15:0] first_bad_ff, first_bad_in;

   always_comb begin
      logic       held;
      logic [3:0] hn;
      logic       zp;
      logic       es;
      logic [15:0] fb;
      logic       bv;
      logic [7:0] bval;
      logic [4:0] hv;
      held = nibble_held_ff;
      hn   = high_nibble_ff;
      zp   = zero_pending_ff;
      es   = error_seen_ff;
      fb   = first_bad_ff;
      bv   = 1'b0;
      bval = 8'd0;
      hv   = hex_value(char_code);
      if (has_char && !es) begin
         if (zp && (char_code == CHAR_LOW_X || char_code == CHAR_UP_X)) begin
            zp = 1'b0;
         end else begin
            if (zp) begin
               zp = 1'b0;
               if (held) begin
                  bv   = 1'b1;
                  bval = {hn, 4'd0};
                  held = 1'b0;
               end else begin
                  held = 1'b1;
               end
               hn = 4'd0;
            end
            if (is_separator(char_code)) begin
               zp = zp;
            end else if (char_code == CHAR_ZERO) begin
               zp = 1'b1;
            end else if (!hv[4]) begin
               es = 1'b1;
               fb = char_code;
            end else if (held) begin
               bv   = 1'b1;
               bval = {hn, hv[3:0]};
               held = 1'b0;
               hn   = 4'd0;
            end else begin
               held = 1'b1;
               hn   = hv[3:0];
            end
         end
      end
      if (end_of_text && zp && !es) begin
         zp = 1'b0;
         if (held) begin
            bv   = 1'b1;
            bval = {hn, 4'd0};
            held = 1'b0;
         end else begin
            held = 1'b1;
         end
         hn = 4'd0;
      end

      entry.has_byte = bv;
      entry.byte_val = bval;
      entry.is_end   = end_of_text;
      entry.bad_char = es ? fb : 16'd0;
      entry.term     = TERM_NONE;
      if (es) begin
         entry.status = STATUS_BAD_HEX;
      end else if (held) begin
         entry.status = STATUS_ODD;
      end else begin
         entry.status = STATUS_OK;
         if (end_of_text && term_mode_ff >= TERM_LF && term_mode_ff <= TERM_NUL) begin
            entry.term = term_mode_ff;
         end
      end
      push = accept && (bv || end_of_text);

      if (end_of_text) begin
         high_nibble_in  = 4'd0;
         nibble_held_in  = 1'b0;
         zero_pending_in = 1'b0;
         error_seen_in   = 1'b0;
         first_bad_in    = 16'd0;
      end else begin
         high_nibble_in  = hn;
         nibble_held_in  = held;
         zero_pending_in = zp;
         error_seen_in   = es;
         first_bad_in    = fb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_mode_ff    <= TERM_NONE;
         high_nibble_ff  <= 4'd0;
         nibble_held_ff  <= 1'b0;
         zero_pending_ff <= 1'b0;
         error_seen_ff   <= 1'b0;
         first_bad_ff    <= 16'd0;
      end else begin
         if (csr_write_enable) begin
            term_mode_ff <= csr_write_data;
         end
         if (accept) begin
            high_nibble_ff  <= high_nibble_in;
            nibble_held_ff  <= nibble_held_in;
            zero_pending_ff <= zero_pending_in;
            error_seen_ff   <= error_seen_in;
            first_bad_ff    <= first_bad_in;
         end
      end
   end

`ifndef ASSERT_OFF
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_text |=> !nibble_held_ff && !zero_pending_ff && !error_seen_ff)
      else $error("message state not cleared after end item");
   a_held_nibble_zero: assert property (@(posedge clock) disable iff (reset)
      !nibble_held_ff |-> high_nibble_ff == 4'd0)
      else $error("stale high nibble without a held digit");
`endif

endmodule

[hw/rtl/hextb_queue.sv]
// ---------------------------------------------------------------------------
// Hex text decoder entry queue
// Short first-in first-out buffer between the front end and the back end.
// ---------------------------------------------------------------------------
module hextb_queue #(
   parameter int Depth = hextb_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hextb_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output hextb_pkg::entry_type head_entry
);
   import hextb_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type           slots_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     count_ff, count_in;

   assign full       = count_ff == CntW'(Depth);
   assign head_valid = count_ff != '0;
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");
`endif

endmodule

[hw/rtl/hextb_back.sv]
// ---------------------------------------------------------------------------
// Hex text decoder back end
// Expands each queue entry into the data byte, termination bytes and status
// word that it carries, and holds the word offered on the result ports.
// ---------------------------------------------------------------------------
module hextb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  hextb_pkg::entry_type head_entry,
   output logic                 pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic                 rsp_kind,
   output logic [7:0]           rsp_byte_value,
   output logic [1:0]           rsp_status_code,
   output logic [15:0]          rsp_bad_char,
   output logic                 rsp_last_result
);
   import hextb_pkg::*;

   logic [1:0]  step_ff;
   logic        out_valid_ff;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] bad_ff, bad_in;
   logic        last_ff, last_in;
   logic [3:0]  present;
   logic [1:0]  sel;
   logic        more;
   logic        advance;

   assign present = {head_entry.is_end, head_entry.term == TERM_CRLF,
                     head_entry.term != TERM_NONE, head_entry.has_byte};
   assign advance = head_valid && (!out_valid_ff || rsp_pop);
   assign pop     = advance && !more;

   always_comb begin
      logic found;
      found = 1'b0;
      sel   = STEP_STAT;
      more  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!found && present[i] && 2'(i) >= step_ff) begin
            found = 1'b1;
            sel   = 2'(i);
         end
      end
      for (int j = 0; j < 4; j++) begin
         if (present[j] && 2'(j) > sel) begin
            more = 1'b1;
         end
      end
   end

   always_comb begin
      kind_in   = KIND_BYTE;
      byte_in   = 8'd0;
      status_in = STATUS_OK;
      bad_in    = 16'd0;
      last_in   = 1'b0;
      unique case (sel)
         STEP_DATA: begin
            byte_in = head_entry.byte_val;
         end
         STEP_TERM1: begin
            if (head_entry.term == TERM_LF) begin
               byte_in = BYTE_LF;
            end else if (head_entry.term == TERM_NUL) begin
               byte_in = BYTE_NUL;
            end else begin
               byte_in = BYTE_CR;
            end
         end
         STEP_TERM2: begin
            byte_in = BYTE_LF;
         end
         STEP_STAT: begin
            kind_in   = KIND_STATUS;
            status_in = head_entry.status;
            bad_in    = head_entry.bad_char;
            last_in   = 1'b1;
         end
         default: begin
            kind_in = KIND_BYTE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
         bad_ff    <= bad_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_DATA;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            step_ff      <= more ? sel + 2'd1 : STEP_DATA;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_byte_value  = byte_ff;
   assign rsp_status_code = status_ff;
   assign rsp_bad_char    = bad_ff;
   assign rsp_last_result = last_ff;

`ifndef ASSERT_OFF
   a_entry_has_work: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> present != 4'd0)
      else $error("queue entry carries no result");
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (kind_ff == KIND_STATUS) == last_ff)
      else $error("status word and last flag disagree");
`endif

endmodule

[hw/rtl/hex_text_to_bytes_core.sv]
// ---------------------------------------------------------------------------
// Hex text to bytes decoder
// Path: a result passes the entry queue, then the result register.
// Throughput: one character per cycle while the queue is not full; an end
// item yields up to four result words: data, termination bytes and status.
// Reset: synchronous; clears message state, queue and result valid flag.
// ---------------------------------------------------------------------------
module hex_text_to_bytes_core #(
   parameter int QueueDepth = hextb_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_char_code,
   input  logic        req_has_char,
   input  logic        req_end_of_text,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [1:0]  rsp_status_code,
   output logic [15:0] rsp_bad_char,
   output logic        rsp_last_result
);
   import hextb_pkg::*;

   logic      accept;
   logic      q_push;
   entry_type q_entry;
   logic      q_pop;
   logic      q_head_valid;
   entry_type q_head;

   assign accept = push && !full;

   hextb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .char_code        (req_char_code),
      .has_char         (req_has_char),
      .end_of_text      (req_end_of_text),
      .push             (q_push),
      .entry            (q_entry)
   );

   hextb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (full),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   hextb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_entry      (q_head),
      .pop             (q_pop),
      .rsp_pop         (pop),
      .rsp_empty       (empty),
      .rsp_kind        (rsp_kind),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_status_code (rsp_status_code),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_last_result (rsp_last_result)
   );

endmodule
